>>> hw/rtl/att_pkg.sv
// att_pkg: widths, beat and lane types, CORDIC angle table and divider constants
// for the accelerometer tilt-angle pipeline.
// No dependencies; every other file of the block uses it.
package att_pkg;

  // Output scaling: degrees * 2^ANGLE_FRAC_BITS (valid range 4..14)
  localparam int ANGLE_FRAC_BITS = 8;

  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 16;
  localparam int NUM_LANES  = 2;        // lane 0: x tilt, lane 1: y tilt

  // Front end: squares, sums, normalization
  localparam int SQ_W       = 31;       // square of a 16-bit sample
  localparam int SUM_W      = 32;       // sum of two squares
  localparam int BL_W       = 6;        // bit length of a SUM_W value
  localparam int SH_W       = 5;        // normalization shift, 14..30
  localparam int NUM_W      = 32;       // normalized numerator, |v| < 2^30

  // Square root row
  localparam int RAD_W      = 60;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;

  // CORDIC row
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 33;
  localparam int Z_W          = 63;
  localparam int TAB_W        = 64;

  // Back end: magnitude, dividend, rounding divider
  localparam int ABS_SHIFT  = 20;
  localparam int A_W        = Z_W - ABS_SHIFT;
  localparam int QUO_W      = ANGLE_FRAC_BITS + 7;
  localparam int QIDX_W     = $clog2(QUO_W);
  localparam int DIVD_W     = ANGLE_FRAC_BITS + 49;
  localparam int SAT_W      = 32;

  localparam logic [1:0] LANE_NEGATE = 2'b10;  // y tilt is the negated angle

  localparam logic [TAB_W-1:0] ONE_60 = TAB_W'(1) << 60;

  // Shift-subtract division, used only while the table below is elaborated
  function automatic logic [TAB_W-1:0] udiv64(logic [TAB_W-1:0] n, logic [TAB_W-1:0] d);
    logic [TAB_W-1:0] q;
    logic [TAB_W-1:0] r;
    q = '0;
    r = '0;
    for (int i = TAB_W - 1; i >= 0; i--) begin
      r = {r[TAB_W-2:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/m) * 2^60 by truncated integer Taylor series
  function automatic logic [TAB_W-1:0] atan_recip(logic [TAB_W-1:0] m);
    logic [TAB_W-1:0] p;
    logic [TAB_W-1:0] msq;
    logic [TAB_W-1:0] sum;
    logic [TAB_W-1:0] t;
    logic             done;
    p    = udiv64(ONE_60, m);
    msq  = m * m;
    sum  = p;
    done = 1'b0;
    t    = '0;
    for (int k = 1; k < TAB_W; k++) begin
      if (!done) begin
        p = udiv64(p, msq);
        if (p == '0) begin
          done = 1'b1;
        end else begin
          t = udiv64(p, TAB_W'(2 * k + 1));
          if (k[0]) begin
            sum = sum - t;
          end else begin
            sum = sum + t;
          end
        end
      end
    end
    return sum;
  endfunction

  typedef logic [CORDIC_STEPS-1:0][TAB_W-1:0] atan_tab_t;

  // atan(2^-i) * 2^60; atan(1) taken as atan(1/2) + atan(1/3)
  function automatic atan_tab_t atan_table();
    atan_tab_t tab;
    tab[0] = atan_recip(TAB_W'(2)) + atan_recip(TAB_W'(3));
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      tab[i] = atan_recip(TAB_W'(1) << i);
    end
    return tab;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_table();

  // Rounding divisor: 2 * (atan(1) * 2^60 >> 20); dividend offset: half of it
  localparam logic [DIVD_W-1:0] HALF_DIV = DIVD_W'(ATAN_TAB[0] >> ABS_SHIFT);
  localparam logic [DIVD_W-1:0] DIVISOR  = HALF_DIV << 1;

  localparam logic [QUO_W-1:0]        ANGLE_LIM = QUO_W'(90) << ANGLE_FRAC_BITS;
  localparam logic signed [SAT_W-1:0] SAT_MAX   = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0] SAT_MIN   = -SAT_W'(32768);

  // Channel beats
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } sample_beat_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] x_tilt;
    logic signed [ANGLE_W-1:0] y_tilt;
  } tilt_beat_t;

  // Square root row, one lane
  typedef struct packed {
    logic [RAD_W-1:0]        rad;   // radicand, consumed two bits a step
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [NUM_W-1:0] num;   // normalized numerator, passed along
    logic                    zero;
  } sqrt_lane_t;
  typedef sqrt_lane_t [NUM_LANES-1:0] sqrt_bus_t;

  // CORDIC row, one lane
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
  } cord_lane_t;
  typedef cord_lane_t [NUM_LANES-1:0] cord_bus_t;

  // Divider row, one lane
  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic              neg;
    logic              zero;
  } div_lane_t;
  typedef div_lane_t [NUM_LANES-1:0] div_bus_t;

endpackage

>>> hw/rtl/att_if.sv
// att_if: valid/ready channel interfaces for the tilt-angle block.
// Depends on att_pkg for the beat types.
interface att_sample_if;
  logic                  valid;
  logic                  ready;
  att_pkg::sample_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface att_tilt_if;
  logic                valid;
  logic                ready;
  att_pkg::tilt_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/att_sqrt_cell.sv
// att_sqrt_cell: one step of the pipelined integer square root, both lanes.
// Takes two radicand bits, yields one root bit. Depends on att_pkg.
module att_sqrt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  att_pkg::sqrt_bus_t lane_i,
  output logic               vld_o,
  output att_pkg::sqrt_bus_t lane_o
);
  import att_pkg::*;

  sqrt_bus_t         lane_d;
  sqrt_bus_t         lane_q;
  logic              vld_q;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;

  // Restoring step: rem = 4*rem + next pair, trial = 4*root + 1
  always_comb begin
    lane_d = lane_i;
    rem_sh = '0;
    trial  = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      rem_sh = {lane_i[l].rem[REM_W-3:0], lane_i[l].rad[RAD_W-1 -: 2]};
      trial  = REM_W'({lane_i[l].root, 2'b01});
      lane_d[l].rad = lane_i[l].rad << 2;
      if (rem_sh >= trial) begin
        lane_d[l].rem  = rem_sh - trial;
        lane_d[l].root = {lane_i[l].root[ROOT_W-2:0], 1'b1};
      end else begin
        lane_d[l].rem  = rem_sh;
        lane_d[l].root = {lane_i[l].root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

>>> hw/rtl/att_cordic_cell.sv
// att_cordic_cell: one vectoring CORDIC micro-rotation, both lanes.
// The step index is tied to a constant per position. Depends on att_pkg.
module att_cordic_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [att_pkg::STEP_IDX_W-1:0] idx_i,
  input  logic                           vld_i,
  input  att_pkg::cord_bus_t             lane_i,
  output logic                           vld_o,
  output att_pkg::cord_bus_t             lane_o
);
  import att_pkg::*;

  cord_bus_t              lane_d;
  cord_bus_t              lane_q;
  logic                   vld_q;
  logic signed [XY_W-1:0] xv;
  logic signed [XY_W-1:0] yv;
  logic signed [Z_W-1:0]  ang;

  // Rotate toward y = 0; a positive y rotates clockwise
  always_comb begin
    lane_d = lane_i;
    ang    = Z_W'(ATAN_TAB[idx_i]);
    xv     = '0;
    yv     = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      xv = lane_i[l].x;
      yv = lane_i[l].y;
      if (yv > 0) begin
        lane_d[l].x = xv + (yv >>> idx_i);
        lane_d[l].y = yv - (xv >>> idx_i);
        lane_d[l].z = lane_i[l].z + ang;
      end else begin
        lane_d[l].x = xv - (yv >>> idx_i);
        lane_d[l].y = yv + (xv >>> idx_i);
        lane_d[l].z = lane_i[l].z - ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

>>> hw/rtl/att_div_cell.sv
// att_div_cell: one quotient bit of the restoring divide by the fixed
// degree-scaling divisor, both lanes. Depends on att_pkg.
module att_div_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [att_pkg::QIDX_W-1:0] idx_i,
  input  logic                       vld_i,
  input  att_pkg::div_bus_t          lane_i,
  output logic                       vld_o,
  output att_pkg::div_bus_t          lane_o
);
  import att_pkg::*;

  div_bus_t          lane_d;
  div_bus_t          lane_q;
  logic              vld_q;
  logic [DIVD_W-1:0] trial;

  // Compare against divisor << idx, subtract on hit, shift in the bit
  always_comb begin
    lane_d = lane_i;
    trial  = DIVISOR << idx_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (lane_i[l].rem >= trial) begin
        lane_d[l].rem = lane_i[l].rem - trial;
        lane_d[l].quo = {lane_i[l].quo[QUO_W-2:0], 1'b1};
      end else begin
        lane_d[l].quo = {lane_i[l].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign vld_o  = vld_q;
  assign lane_o = lane_q;

endmodule

>>> hw/rtl/accel_tilt_angles.sv
// accel_tilt_angles: tilt angles from one accelerometer sample triple.
// Depends on att_pkg, att_if (channels) and the cells att_sqrt_cell,
// att_cordic_cell and att_div_cell.
//
//   port      dir  beat                         handshake
//   sample_i  in   accel_x, accel_y, accel_z    valid/ready
//   tilt_o    out  x_tilt, y_tilt               valid/ready
//
// One beat per cycle in, one per cycle out, while tilt_o.ready holds. A
// result passes from its sample through 3 front-end stages, 30 square-root
// cells, 32 CORDIC cells, 2 back-end stages, ANGLE_FRAC_BITS + 7 divider
// cells and the output register.
// Reset clears the valid bits only. A stalled output fills a one-beat skid
// register; only then does the pipe hold and sample_i.ready drop.
module accel_tilt_angles (
  input  logic              clk_i,
  input  logic              rst_ni,
  att_sample_if.sink        sample_i,
  att_tilt_if.source        tilt_o
);
  import att_pkg::*;

  logic en;

  // ---------------- stage 1: squares ----------------
  logic                       s1_vld_q;
  logic [SQ_W-1:0]            s1_sa_q  [NUM_LANES];  // square summed with z^2
  logic [SQ_W-1:0]            s1_sn_q  [NUM_LANES];  // square of the numerator
  logic [SQ_W-1:0]            s1_z2_q;
  logic signed [SAMPLE_W-1:0] s1_n_q   [NUM_LANES];
  logic signed [2*SAMPLE_W-1:0] prod_x;
  logic signed [2*SAMPLE_W-1:0] prod_y;
  logic signed [2*SAMPLE_W-1:0] prod_z;

  assign prod_x = sample_i.data.accel_x * sample_i.data.accel_x;
  assign prod_y = sample_i.data.accel_y * sample_i.data.accel_y;
  assign prod_z = sample_i.data.accel_z * sample_i.data.accel_z;

  assign sample_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sa_q[0] <= prod_x[SQ_W-1:0];
      s1_sa_q[1] <= prod_y[SQ_W-1:0];
      s1_sn_q[0] <= prod_y[SQ_W-1:0];
      s1_sn_q[1] <= prod_x[SQ_W-1:0];
      s1_z2_q    <= prod_z[SQ_W-1:0];
      s1_n_q[0]  <= sample_i.data.accel_y;
      s1_n_q[1]  <= sample_i.data.accel_x;
    end
  end

  // ---------------- stage 2: sums and magnitude bound ----------------
  logic                       s2_vld_q;
  logic [SUM_W-1:0]           s2_s_q [NUM_LANES];
  logic [SUM_W-1:0]           s2_m_q [NUM_LANES];
  logic signed [SAMPLE_W-1:0] s2_n_q [NUM_LANES];
  logic [SUM_W-1:0]           s2_s_d [NUM_LANES];
  logic [SUM_W-1:0]           s2_m_d [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      s2_s_d[l] = SUM_W'(s1_sa_q[l]) + SUM_W'(s1_z2_q);
      s2_m_d[l] = (s2_s_d[l] > SUM_W'(s1_sn_q[l])) ? s2_s_d[l] : SUM_W'(s1_sn_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_s_q <= s2_s_d;
      s2_m_q <= s2_m_d;
      s2_n_q <= s1_n_q;
    end
  end

  // ---------------- stage 3: normalize by 4^sh ----------------
  logic             s3_vld_q;
  sqrt_bus_t        s3_bus_q;
  sqrt_bus_t        s3_bus_d;
  logic [BL_W-1:0]  blen;
  logic [SH_W-1:0]  sh;

  // sh is the largest k with max(s, n^2) * 4^k below 2^60
  always_comb begin
    s3_bus_d = '0;
    blen     = '0;
    sh       = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      blen = '0;
      for (int b = 0; b < SUM_W; b++) begin
        if (s2_m_q[l][b]) begin
          blen = BL_W'(b + 1);
        end
      end
      sh = SH_W'((BL_W'(60) - blen) >> 1);
      s3_bus_d[l].rad  = RAD_W'(s2_s_q[l]) << {sh, 1'b0};
      s3_bus_d[l].rem  = '0;
      s3_bus_d[l].root = '0;
      s3_bus_d[l].num  = {{(NUM_W-SAMPLE_W){s2_n_q[l][SAMPLE_W-1]}}, s2_n_q[l]} << sh;
      s3_bus_d[l].zero = (s2_m_q[l] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_bus_q <= s3_bus_d;
    end
  end

  // ---------------- square root row ----------------
  logic      sq_vld [SQRT_STEPS+1];
  sqrt_bus_t sq_bus [SQRT_STEPS+1];

  assign sq_vld[0] = s3_vld_q;
  assign sq_bus[0] = s3_bus_q;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    att_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[g]),
      .lane_i (sq_bus[g]),
      .vld_o  (sq_vld[g+1]),
      .lane_o (sq_bus[g+1])
    );
  end

  // ---------------- CORDIC row ----------------
  logic      co_vld [CORDIC_STEPS+1];
  cord_bus_t co_bus [CORDIC_STEPS+1];

  // Start vector: (isqrt, numerator), angle zero
  always_comb begin
    co_bus[0] = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      co_bus[0][l].x    = XY_W'(sq_bus[SQRT_STEPS][l].root);
      co_bus[0][l].y    = {{(XY_W-NUM_W){sq_bus[SQRT_STEPS][l].num[NUM_W-1]}},
                           sq_bus[SQRT_STEPS][l].num};
      co_bus[0][l].z    = '0;
      co_bus[0][l].zero = sq_bus[SQRT_STEPS][l].zero;
    end
  end

  assign co_vld[0] = sq_vld[SQRT_STEPS];

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    att_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (STEP_IDX_W'(g)),
      .vld_i  (co_vld[g]),
      .lane_i (co_bus[g]),
      .vld_o  (co_vld[g+1]),
      .lane_o (co_bus[g+1])
    );
  end

  // ---------------- back end: magnitude ----------------
  logic            ab_vld_q;
  logic [A_W-1:0]  ab_a_q    [NUM_LANES];
  logic            ab_neg_q  [NUM_LANES];
  logic            ab_zero_q [NUM_LANES];
  logic [Z_W-1:0]  zmag      [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      zmag[l] = co_bus[CORDIC_STEPS][l].z[Z_W-1] ? Z_W'(-co_bus[CORDIC_STEPS][l].z)
                                                 : Z_W'(co_bus[CORDIC_STEPS][l].z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_vld_q <= 1'b0;
    end else if (en) begin
      ab_vld_q <= co_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        ab_a_q[l]    <= zmag[l][Z_W-1:ABS_SHIFT];
        ab_neg_q[l]  <= co_bus[CORDIC_STEPS][l].z[Z_W-1] ^ LANE_NEGATE[l];
        ab_zero_q[l] <= co_bus[CORDIC_STEPS][l].zero;
      end
    end
  end

  // ---------------- back end: dividend = 2*(a*45 << F) + divisor/2 ----------------
  logic              dd_vld_q;
  div_bus_t          dd_bus_q;
  div_bus_t          dd_bus_d;
  logic [DIVD_W-1:0] a_ext;
  logic [DIVD_W-1:0] a45;

  always_comb begin
    dd_bus_d = '0;
    a_ext    = '0;
    a45      = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      a_ext = DIVD_W'(ab_a_q[l]);
      a45   = (a_ext << 5) + (a_ext << 3) + (a_ext << 2) + a_ext;
      dd_bus_d[l].rem  = (a45 << (ANGLE_FRAC_BITS + 1)) + HALF_DIV;
      dd_bus_d[l].quo  = '0;
      dd_bus_d[l].neg  = ab_neg_q[l];
      dd_bus_d[l].zero = ab_zero_q[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dd_vld_q <= 1'b0;
    end else if (en) begin
      dd_vld_q <= ab_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_bus_q <= dd_bus_d;
    end
  end

  // ---------------- divider row, MSB first ----------------
  logic     dv_vld [QUO_W+1];
  div_bus_t dv_bus [QUO_W+1];

  assign dv_vld[0] = dd_vld_q;
  assign dv_bus[0] = dd_bus_q;

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    att_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .idx_i  (QIDX_W'(QUO_W - 1 - g)),
      .vld_i  (dv_vld[g]),
      .lane_i (dv_bus[g]),
      .vld_o  (dv_vld[g+1]),
      .lane_o (dv_bus[g+1])
    );
  end

  // ---------------- clamp, sign, saturate ----------------
  tilt_beat_t              res_beat;
  logic [QUO_W-1:0]        qc     [NUM_LANES];
  logic signed [SAT_W-1:0] sval   [NUM_LANES];
  logic signed [SAT_W-1:0] ssat   [NUM_LANES];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (dv_bus[QUO_W][l].zero) begin
        qc[l] = '0;
      end else if (dv_bus[QUO_W][l].quo > ANGLE_LIM) begin
        qc[l] = ANGLE_LIM;
      end else begin
        qc[l] = dv_bus[QUO_W][l].quo;
      end
      sval[l] = dv_bus[QUO_W][l].neg ? -$signed(SAT_W'(qc[l])) : $signed(SAT_W'(qc[l]));
      if (sval[l] > SAT_MAX) begin
        ssat[l] = SAT_MAX;
      end else if (sval[l] < SAT_MIN) begin
        ssat[l] = SAT_MIN;
      end else begin
        ssat[l] = sval[l];
      end
    end
    res_beat.x_tilt = ssat[0][ANGLE_W-1:0];
    res_beat.y_tilt = ssat[1][ANGLE_W-1:0];
  end

  // ---------------- output register and skid ----------------
  logic       out_vld_q;
  logic       skid_vld_q;
  tilt_beat_t out_data_q;
  tilt_beat_t skid_data_q;
  logic       push;
  logic       take;

  assign en   = !skid_vld_q;
  assign push = en && dv_vld[QUO_W];
  assign take = out_vld_q && tilt_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || take) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || take) begin
      if (skid_vld_q) begin
        out_data_q <= skid_data_q;
      end else if (push) begin
        out_data_q <= res_beat;
      end
    end else if (push) begin
      skid_data_q <= res_beat;
    end
  end

  assign tilt_o.valid = out_vld_q;
  assign tilt_o.data  = out_data_q;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for accel_tilt_angles, with a bit-exact tilt predictor and scoreboard.
// Depends on att_pkg (beat types, ANGLE_FRAC_BITS), att_if (channels) and the block's RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import att_pkg::*;

  localparam int LATENCY     = 74 + ANGLE_FRAC_BITS;
  localparam int DRAIN       = 2 * LATENCY + 20;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_BEATS = 1900;
  localparam int REPORT_MAX  = 10;

  // Scoreboard: predicts both tilt angles for each sample and checks result beats in order
  class tilt_scoreboard;
    localparam longint unsigned UNIT_60 = 64'd1 << 60;

    longint     atan_lut[CORDIC_STEPS];
    tilt_beat_t tilts_due[$];
    int         mismatches;

    function new();
      atan_lut[0] = atan_inv(2) + atan_inv(3);
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        atan_lut[i] = atan_inv(64'd1 << i);
      end
      mismatches = 0;
    endfunction

    // atan(1/m) * 2^60, truncated integer series
    function longint atan_inv(longint unsigned m);
      longint unsigned p;
      longint unsigned msq;
      longint unsigned k;
      longint          acc;
      p   = UNIT_60 / m;
      msq = m * m;
      acc = longint'(p);
      k   = 1;
      p   = p / msq;
      while (p != 0) begin
        if (k[0]) begin
          acc -= longint'(p / (2 * k + 1));
        end else begin
          acc += longint'(p / (2 * k + 1));
        end
        k++;
        p = p / msq;
      end
      return acc;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
        if (v >= root + probe) begin
          v    = v - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root >>= 1;
        end
        probe >>= 2;
      end
      return root;
    endfunction

    // atan2(n, sqrt(s)) in degrees * 2^ANGLE_FRAC_BITS, clamped to +-90
    function longint angle_of(longint n, longint unsigned s);
      longint unsigned nsq;
      longint unsigned m;
      longint unsigned a;
      longint unsigned a40;
      longint unsigned num;
      longint unsigned q;
      longint unsigned lim;
      longint          xr;
      longint          yr;
      longint          zr;
      longint          nx;
      longint          ny;
      int              sh;
      nsq = n * n;
      m   = (s > nsq) ? s : nsq;
      if (m == 0) return 0;
      // normalize so the larger square sits just under 2^60
      sh = 0;
      while (sh < 30 && m < (UNIT_60 >> (2 * (sh + 1)))) sh++;
      xr = longint'(int_sqrt(s << (2 * sh)));
      yr = n * (longint'(1) << sh);
      zr = 0;
      // vectoring pass, floor shifts
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (yr > 0) begin
          nx = xr + (yr >>> i);
          ny = yr - (xr >>> i);
          zr += atan_lut[i];
        end else begin
          nx = xr - (yr >>> i);
          ny = yr + (xr >>> i);
          zr -= atan_lut[i];
        end
        xr = nx;
        yr = ny;
      end
      // radians to degrees, round half up
      a   = (zr < 0) ? -zr : zr;
      a   = a >> 20;
      a40 = atan_lut[0] >> 20;
      num = (a * 45) << ANGLE_FRAC_BITS;
      q   = (2 * num + a40) / (2 * a40);
      lim = 64'd90 << ANGLE_FRAC_BITS;
      if (q > lim) q = lim;
      return (zr < 0) ? -longint'(q) : longint'(q);
    endfunction

    function logic [ANGLE_W-1:0] sat16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[ANGLE_W-1:0];
    endfunction

    function void note_sample(sample_beat_t s);
      tilt_beat_t t;
      longint     x;
      longint     y;
      longint     z;
      x = s.accel_x;
      y = s.accel_y;
      z = s.accel_z;
      t.x_tilt = sat16(angle_of(y, x * x + z * z));
      t.y_tilt = sat16(-angle_of(x, y * y + z * z));
      tilts_due.push_back(t);
    endfunction

    function void check_tilt(tilt_beat_t got);
      tilt_beat_t want;
      if (tilts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected tilt beat: x_tilt=%0d y_tilt=%0d", got.x_tilt, got.y_tilt);
        return;
      end
      want = tilts_due.pop_front();
      if (got.x_tilt !== want.x_tilt || got.y_tilt !== want.y_tilt) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          if (got.x_tilt !== want.x_tilt)
            $display("x_tilt mismatch: expected %0d, got %0d", want.x_tilt, got.x_tilt);
          if (got.y_tilt !== want.y_tilt)
            $display("y_tilt mismatch: expected %0d, got %0d", want.y_tilt, got.y_tilt);
        end
      end
    endfunction

    function int pending();
      return tilts_due.size();
    endfunction

    function bit clean();
      return mismatches == 0 && tilts_due.size() == 0;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady_flow = 1'b0;   // no idling on either side while set
  int   cycles = 0;

  att_sample_if sample_if ();
  att_tilt_if   tilt_if ();

  tilt_scoreboard sb = new();

  accel_tilt_angles dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .tilt_o   (tilt_if)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: random backpressure, check every accepted beat
  initial tilt_if.ready = 1'b0;
  always @(negedge clk_i) begin
    tilt_if.ready <= steady_flow || ($urandom_range(99) >= 33);
  end
  always @(posedge clk_i) begin
    if (rst_ni && tilt_if.valid && tilt_if.ready) sb.check_tilt(tilt_if.data);
  end

  // Drive one sample beat; called and returns at a falling edge
  task automatic send_sample(sample_beat_t s);
    while (!steady_flow && $urandom_range(99) < 33) begin
      sample_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    sample_if.valid <= 1'b1;
    sample_if.data  <= s;
    do @(posedge clk_i); while (!(sample_if.valid && sample_if.ready));
    sb.note_sample(s);
    @(negedge clk_i);
  endtask

  task automatic send_xyz(int x, int y, int z);
    sample_beat_t s;
    s.accel_x = x[SAMPLE_W-1:0];
    s.accel_y = y[SAMPLE_W-1:0];
    s.accel_z = z[SAMPLE_W-1:0];
    send_sample(s);
  endtask

  function automatic int rand_span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic int rand_extreme();
    case ($urandom_range(5))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      default: return 32767;
    endcase
  endfunction

  // Random sample with a bias toward realistic and corner-heavy vectors
  function automatic sample_beat_t rand_sample();
    sample_beat_t s;
    int           v[3];
    int           big;
    int           pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      s = sample_beat_t'(48'({$urandom, $urandom}));
      return s;
    end else if (pick < 60) begin
      // near one-g on one axis, small tilt on the others
      big = $urandom_range(2);
      for (int i = 0; i < 3; i++) v[i] = rand_span(2000);
      v[big] = ($urandom_range(1) ? 1 : -1) * int'($urandom_range(20000, 12000));
    end else if (pick < 75) begin
      for (int i = 0; i < 3; i++) v[i] = $urandom_range(1) ? rand_span(8) : rand_span(255);
    end else if (pick < 85) begin
      for (int i = 0; i < 3; i++) v[i] = $urandom_range(2) == 0 ? 0 : rand_span(32767);
    end else begin
      for (int i = 0; i < 3; i++) v[i] = rand_extreme();
    end
    s.accel_x = v[0][SAMPLE_W-1:0];
    s.accel_y = v[1][SAMPLE_W-1:0];
    s.accel_z = v[2][SAMPLE_W-1:0];
    return s;
  endfunction

  initial begin
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero vector, axis extremes, pure numerators, 45-degree cases
    send_xyz(0, 0, 0);
    send_xyz(0, 0, 32767);
    send_xyz(0, 0, -32768);
    send_xyz(32767, 0, 0);
    send_xyz(-32768, 0, 0);
    send_xyz(0, 32767, 0);
    send_xyz(0, -32768, 0);
    send_xyz(-32768, -32768, -32768);
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, 32767, -32768);
    send_xyz(32767, -32768, 32767);
    send_xyz(1, 0, 0);
    send_xyz(0, -1, 0);
    send_xyz(0, 0, 1);
    send_xyz(1, 1, 1);
    send_xyz(-1, -1, -1);
    send_xyz(0, 16384, 16384);
    send_xyz(16384, 0, -16384);
    send_xyz(16384, 16384, 0);
    send_xyz(-32768, -32768, 0);
    send_xyz(-32768, 1, 0);
    send_xyz(1, -32768, 0);
    send_xyz(5, -3, 0);

    // random part, with a long stretch of back-to-back beats in the middle
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      steady_flow = (i >= 700 && i < 1000);
      send_sample(rand_sample());
    end
    steady_flow = 1'b0;
    sample_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (sb.clean()) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
